/* design/bmp8_pkg.sv */
// bmp8_pkg: shared types and constants of the 8-bit palettized bmp writer
// used by every module of the writer; depends on nothing

package bmp8_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int DIM_W     = 13;   // width of the size registers
   localparam int SIZE_W    = 25;   // width of file and image byte counts
   localparam int HPOS_W    = 11;
   localparam int COL_W     = 12;
   localparam int ROWS_W    = 13;

   localparam logic [HPOS_W-1:0] HDR_TOTAL      = 11'd1078;
   localparam logic [HPOS_W-1:0] PALETTE_START  = 11'd54;
   localparam logic [SIZE_W-1:0] HDR_TOTAL_SIZE = 25'd1078;

   localparam logic [7:0] MAGIC_B = 8'h42;
   localparam logic [7:0] MAGIC_M = 8'h4d;

   localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
   localparam logic [31:0] PX_PER_METER  = 32'd2835;
   localparam logic [31:0] NUM_COLORS    = 32'd256;
   localparam logic [7:0]  NUM_PLANES    = 8'd1;
   localparam logic [7:0]  BITS_PER_PX   = 8'd8;

   localparam logic [2:0] CUBE_TOP = 3'd5;    // last level of a cube digit
   localparam logic [7:0] CUBE_STEP = 8'd51;

   // register indexes of the config port
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [SIZE_W-1:0] image_bytes;
      logic [SIZE_W-1:0] file_size;
   } cfg_type;

   // one queued job: a byte followed by pad_count zero bytes
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] pad_count;
      logic       eof;
      logic       status;
   } job_type;

   function automatic logic [7:0] cube_level(input logic [2:0] digit);
      return 8'(digit * CUBE_STEP);
   endfunction

endpackage

/* design/bmp8_csr.sv */
// bmp8_csr: image size registers, clamped at write time, with the derived
// image byte count and file size; depends on bmp8_pkg

module bmp8_csr #(
   parameter int MAX_WIDTH  = bmp8_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmp8_pkg::MAX_HEIGHT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [bmp8_pkg::DIM_W-1:0] csr_wdata,
   output bmp8_pkg::cfg_type          cfg
);

   logic [bmp8_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [bmp8_pkg::DIM_W-1:0]  height_ff, height_in;
   logic [bmp8_pkg::DIM_W-1:0]  padded_width_ff, padded_width_in;
   logic [bmp8_pkg::SIZE_W-1:0] image_bytes_ff, image_bytes_in;
   logic [bmp8_pkg::SIZE_W-1:0] file_size_ff, file_size_in;
   logic [bmp8_pkg::DIM_W-1:0]  clamp_w, clamp_h;
   logic [bmp8_pkg::DIM_W:0]    round_w;

   always_comb begin
      if (csr_wdata == '0) begin
         clamp_w = bmp8_pkg::DIM_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
         clamp_w = bmp8_pkg::DIM_W'(MAX_WIDTH);
      end else begin
         clamp_w = csr_wdata;
      end
      if (csr_wdata == '0) begin
         clamp_h = bmp8_pkg::DIM_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
         clamp_h = bmp8_pkg::DIM_W'(MAX_HEIGHT);
      end else begin
         clamp_h = csr_wdata;
      end
      // row length rounded up to a 4-byte line
      round_w = ({1'b0, clamp_w} + (bmp8_pkg::DIM_W+1)'(3)) & ~(bmp8_pkg::DIM_W+1)'(3);
   end

   always_comb begin
      width_in        = width_ff;
      height_in       = height_ff;
      padded_width_in = padded_width_ff;
      image_bytes_in  = image_bytes_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            bmp8_pkg::CSR_WIDTH: begin
               width_in        = clamp_w;
               padded_width_in = bmp8_pkg::DIM_W'(round_w);
               image_bytes_in  = bmp8_pkg::SIZE_W'(height_ff) *
                                 bmp8_pkg::SIZE_W'(round_w);
            end
            bmp8_pkg::CSR_HEIGHT: begin
               height_in      = clamp_h;
               image_bytes_in = bmp8_pkg::SIZE_W'(clamp_h) *
                                bmp8_pkg::SIZE_W'(padded_width_ff);
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
      file_size_in = bmp8_pkg::HDR_TOTAL_SIZE + image_bytes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff        <= bmp8_pkg::DIM_W'(1);
         height_ff       <= bmp8_pkg::DIM_W'(1);
         padded_width_ff <= bmp8_pkg::DIM_W'(4);
         image_bytes_ff  <= bmp8_pkg::SIZE_W'(4);
         file_size_ff    <= bmp8_pkg::HDR_TOTAL_SIZE + bmp8_pkg::SIZE_W'(4);
      end else begin
         width_ff        <= width_in;
         height_ff       <= height_in;
         padded_width_ff <= padded_width_in;
         image_bytes_ff  <= image_bytes_in;
         file_size_ff    <= file_size_in;
      end
   end

   assign cfg.width       = width_ff;
   assign cfg.height      = height_ff;
   assign cfg.image_bytes = image_bytes_ff;
   assign cfg.file_size   = file_size_ff;

endmodule

/* design/bmp8_front.sv */
// bmp8_front: accepts items, tracks header, column and row position and
// turns each item into one queued job; depends on bmp8_pkg

module bmp8_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_command,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  bmp8_pkg::cfg_type cfg,
   input  logic              queue_full,
   output logic              push,
   output bmp8_pkg::job_type push_job
);

   logic [bmp8_pkg::HPOS_W-1:0] header_position_ff, header_position_in;
   logic [bmp8_pkg::COL_W-1:0]  column_count_ff, column_count_in;
   logic [bmp8_pkg::ROWS_W-1:0] rows_done_ff, rows_done_in;
   // cube digits of the palette entry being emitted
   logic [2:0] digit0_ff, digit0_in;
   logic [2:0] digit1_ff, digit1_in;
   logic [2:0] digit2_ff, digit2_in;

   logic                        header_done;
   logic [5:0]                  hpos;
   logic [1:0]                  byte_sel;
   logic [31:0]                 field_word;
   logic [7:0]                  header_data;
   logic [1:0]                  lane;
   logic [2:0]                  q_red, q_green, q_blue;
   logic [7:0]                  index;
   logic [bmp8_pkg::COL_W-1:0]  col_next;
   logic [bmp8_pkg::ROWS_W-1:0] rows_next;
   logic                        row_end;
   logic [1:0]                  pad;

   function automatic logic [2:0] quantize(input logic [7:0] v);
      // round(v/51) by thresholds
      if (v >= 8'd230) begin
         return 3'd5;
      end else if (v >= 8'd179) begin
         return 3'd4;
      end else if (v >= 8'd128) begin
         return 3'd3;
      end else if (v >= 8'd77) begin
         return 3'd2;
      end else if (v >= 8'd26) begin
         return 3'd1;
      end
      return 3'd0;
   endfunction

   assign header_done = header_position_ff >= bmp8_pkg::HDR_TOTAL;
   assign hpos        = header_position_ff[5:0];
   // every multi-byte field taken from field_word starts at an offset of 2 mod 4
   assign byte_sel    = hpos[1:0] + 2'd2;
   assign lane        = header_position_ff[1:0] + 2'd2;

   always_comb begin
      field_word = '0;
      case (hpos) inside
         [6'd2:6'd5]:   field_word = 32'(cfg.file_size);
         [6'd10:6'd13]: field_word = 32'(bmp8_pkg::HDR_TOTAL);
         [6'd14:6'd17]: field_word = bmp8_pkg::INFO_HDR_SIZE;
         [6'd18:6'd21]: field_word = 32'(cfg.width);
         [6'd22:6'd25]: field_word = 32'(cfg.height);
         [6'd34:6'd37]: field_word = 32'(cfg.image_bytes);
         [6'd38:6'd45]: field_word = bmp8_pkg::PX_PER_METER;
         [6'd46:6'd49]: field_word = bmp8_pkg::NUM_COLORS;
         default:       field_word = '0;
      endcase
   end

   always_comb begin
      if (header_position_ff >= bmp8_pkg::PALETTE_START) begin
         case (lane)
            2'd0:    header_data = bmp8_pkg::cube_level(digit0_ff);
            2'd1:    header_data = bmp8_pkg::cube_level(digit1_ff);
            2'd2:    header_data = bmp8_pkg::cube_level(digit2_ff);
            default: header_data = 8'd0;
         endcase
      end else begin
         case (hpos)
            6'd0:    header_data = bmp8_pkg::MAGIC_B;
            6'd1:    header_data = bmp8_pkg::MAGIC_M;
            6'd26:   header_data = bmp8_pkg::NUM_PLANES;
            6'd28:   header_data = bmp8_pkg::BITS_PER_PX;
            default: header_data = field_word[byte_sel*8 +: 8];
         endcase
      end
   end

   always_comb begin
      q_red     = quantize(req_red);
      q_green   = quantize(req_green);
      q_blue    = quantize(req_blue);
      index     = 8'(q_red * 8'd36) + 8'(q_green * 8'd6) + 8'(q_blue);
      col_next  = column_count_ff + bmp8_pkg::COL_W'(1);
      rows_next = rows_done_ff + bmp8_pkg::ROWS_W'(1);
      // a wrapped column counter also ends the row
      row_end   = (col_next == '0) || ({1'b0, col_next} >= cfg.width);
      pad       = 2'd0 - cfg.width[1:0];
   end

   assign push = req_valid && !queue_full;

   always_comb begin
      header_position_in = header_position_ff;
      column_count_in    = column_count_ff;
      rows_done_in       = rows_done_ff;
      digit0_in          = digit0_ff;
      digit1_in          = digit1_ff;
      digit2_in          = digit2_ff;
      push_job.data      = 8'd0;
      push_job.pad_count = 2'd0;
      push_job.eof       = 1'b0;
      push_job.status    = 1'b1;
      if (!req_command) begin
         if (!header_done) begin
            push_job.data      = header_data;
            push_job.status    = 1'b0;
            header_position_in = header_position_ff + bmp8_pkg::HPOS_W'(1);
            if (header_position_ff >= bmp8_pkg::PALETTE_START && lane == 2'd3) begin
               digit0_in = (digit0_ff == bmp8_pkg::CUBE_TOP) ? 3'd0 : digit0_ff + 3'd1;
               if (digit0_ff == bmp8_pkg::CUBE_TOP) begin
                  digit1_in = (digit1_ff == bmp8_pkg::CUBE_TOP) ? 3'd0 : digit1_ff + 3'd1;
                  if (digit1_ff == bmp8_pkg::CUBE_TOP) begin
                     digit2_in = (digit2_ff == bmp8_pkg::CUBE_TOP) ? 3'd0 :
                                 digit2_ff + 3'd1;
                  end
               end
            end
         end
      end else if (header_done && rows_done_ff < cfg.height) begin
         push_job.data   = index;
         push_job.status = 1'b0;
         if (row_end) begin
            push_job.pad_count = pad;
            push_job.eof       = rows_next >= cfg.height;
            column_count_in    = '0;
            rows_done_in       = rows_next;
         end else begin
            column_count_in = col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_position_ff <= '0;
         column_count_ff    <= '0;
         rows_done_ff       <= '0;
         digit0_ff          <= '0;
         digit1_ff          <= '0;
         digit2_ff          <= '0;
      end else if (push) begin
         header_position_ff <= header_position_in;
         column_count_ff    <= column_count_in;
         rows_done_ff       <= rows_done_in;
         digit0_ff          <= digit0_in;
         digit1_ff          <= digit1_in;
         digit2_ff          <= digit2_in;
      end
   end

endmodule

/* design/bmp8_job_queue.sv */
// bmp8_job_queue: short fifo of jobs between the front and the back part
// depends on bmp8_pkg

module bmp8_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bmp8_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output bmp8_pkg::job_type head_job
);

   bmp8_pkg::job_type slot_ff [bmp8_pkg::QUEUE_DEPTH];
   logic [bmp8_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bmp8_pkg::QCNT_W-1:0] count_ff;
   logic                        do_push, do_pop;

   assign full       = count_ff == bmp8_pkg::QCNT_W'(bmp8_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + bmp8_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + bmp8_pkg::QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + bmp8_pkg::QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - bmp8_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

/* design/bmp8_back.sv */
// bmp8_back: expands queued jobs into output bytes with row padding and
// holds the output register; depends on bmp8_pkg

module bmp8_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  bmp8_pkg::job_type           head_job,
   input  bmp8_pkg::cfg_type           cfg,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_end_of_file,
   output logic                        rsp_status,
   output logic [bmp8_pkg::SIZE_W-1:0] rsp_file_size
);

   logic                        valid_ff;
   logic [7:0]                  byte_ff;
   logic                        last_ff, eof_ff, status_ff;
   logic [bmp8_pkg::SIZE_W-1:0] size_ff;
   logic [1:0]                  sub_ff, sub_in;   // byte within the current job
   logic                        load, last;

   assign load = !valid_ff || !rsp_stall;
   assign last = sub_ff == head_job.pad_count;
   assign pop  = load && head_valid && last;

   always_comb begin
      sub_in = sub_ff;
      if (pop) begin
         sub_in = 2'd0;
      end else if (load && head_valid) begin
         sub_in = sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         sub_ff <= sub_in;
         if (load) begin
            valid_ff <= head_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         byte_ff   <= (sub_ff == 2'd0) ? head_job.data : 8'd0;
         last_ff   <= last;
         eof_ff    <= head_job.eof && last;
         status_ff <= head_job.status;
         size_ff   <= cfg.file_size;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_end_of_file = eof_ff;
   assign rsp_status      = status_ff;
   assign rsp_file_size   = size_ff;

endmodule

/* design/bmp8_palette_image_writer_unit.sv */
// bmp8_palette_image_writer_unit: top level of the 8-bit palettized bmp writer
// depends on bmp8_pkg, bmp8_csr, bmp8_front, bmp8_job_queue and bmp8_back
//
//   port group | dir  | carries
//   req_*      | in   | command, red, green, blue (valid / stall)
//   rsp_*      | out  | out_byte, last_of_run, end_of_file, status, file_size
//   csr_*      | in   | image_width (index 0), image_height (index 1), write only
//
// one item enters per cycle while the job queue has room; each item is one
// job, and the back part sends one byte per cycle unless rsp_stall holds it,
// so a row-end pixel with padding gives up to four bytes and the queue
// absorbs the burst; each item passes the queue, then the output register.
// reset is synchronous and restarts the file at the first header byte with
// both sizes at 1. rsp_stall holds the output register; req_stall rises only
// when the four-entry queue is full.

module bmp8_palette_image_writer_unit #(
   parameter int MAX_WIDTH  = bmp8_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmp8_pkg::MAX_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [7:0]                  req_red,
   input  logic [7:0]                  req_green,
   input  logic [7:0]                  req_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_end_of_file,
   output logic                        rsp_status,
   output logic [bmp8_pkg::SIZE_W-1:0] rsp_file_size,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [bmp8_pkg::DIM_W-1:0]  csr_wdata
);

   bmp8_pkg::cfg_type cfg;
   bmp8_pkg::job_type push_job, head_job;
   logic              push, pop, queue_full, head_valid;

   assign req_stall = queue_full;

   bmp8_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   bmp8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .cfg         (cfg),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   bmp8_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   bmp8_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .cfg             (cfg),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_file (rsp_end_of_file),
      .rsp_status      (rsp_status),
      .rsp_file_size   (rsp_file_size)
   );

endmodule
